// ===== sv/dtsd_pkg.sv =====
// shared types and constants for the top-k squared distance core
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package dtsd_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned PP_W    = 32;

  localparam logic [FIELD_W-1:0] CEIL_RESET = 32'hFFFF_FFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_COORD = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // operation carried by a token walking the cell chain
  typedef enum logic [1:0] {
    OP_DUP,
    OP_INS,
    OP_RD
  } tok_op_e;

  typedef struct packed {
    logic              vld;
    tok_op_e           op;
    logic              dup;
    logic [SLOT_W-1:0] slot;
  } tok_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_DUP,
    ST_INS,
    ST_RD,
    ST_PUSH
  } state_e;

endpackage

`default_nettype wire

// ===== sv/dtsd_in_if.sv =====
// input channel of the top-k squared distance core
// depends on dtsd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dtsd_in_if;
  import dtsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FIELD_W-1:0] coordinate;
  logic [FIELD_W-1:0] mask;
  logic [FIELD_W-1:0] label;
  logic               last_dim;
  logic [SLOT_W-1:0]  slot;
  logic [FIELD_W-1:0] rand_id;
  logic [FIELD_W-1:0] rand_dist;

  modport source (
    output valid, mode, coordinate, mask, label, last_dim, slot, rand_id, rand_dist,
    input  ready
  );

  modport sink (
    input  valid, mode, coordinate, mask, label, last_dim, slot, rand_id, rand_dist,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/dtsd_out_if.sv =====
// result channel of the top-k squared distance core
// depends on dtsd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dtsd_out_if;
  import dtsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] masked_distance;
  logic [FIELD_W-1:0] masked_id;
  logic [SLOT_W-1:0]  slot_echo;

  modport source (
    output valid, masked_distance, masked_id, slot_echo,
    input  ready
  );

  modport sink (
    input  valid, masked_distance, masked_id, slot_echo,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/dtsd_sqacc.sv =====
// subtract, square and accumulate unit for one coordinate per transaction
// depends on dtsd_pkg; squares through two partial products of 32 bit halves
`timescale 1ns / 1ps
`default_nettype none

module dtsd_sqacc #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [dtsd_pkg::FIELD_W-1:0]   coordinate_i,
  input  wire logic [dtsd_pkg::FIELD_W-1:0]   mask_i,
  input  wire logic                           last_i,
  output logic                                step_vld_o,
  output logic                                step_last_o,
  output logic [DATA_WIDTH-1:0]               point_dist_o
);
  import dtsd_pkg::*;

  logic                  s1_vld_q, s1_last_q;
  logic [DATA_WIDTH-1:0] diff_q;
  logic                  s2_vld_q, s2_last_q;
  logic [2*PP_W-1:0]     p0_q;
  logic [PP_W-1:0]       p1_q;
  logic                  step_vld_q, step_last_q;
  logic [DATA_WIDTH-1:0] sum_q, sum_d;
  logic [DATA_WIDTH-1:0] pdist_q;

  logic [2*PP_W-1:0]     diff_ext;
  logic [PP_W-1:0]       lo, hi;
  logic [2*PP_W-1:0]     p0_d;
  logic [PP_W-1:0]       p1_d;
  logic [2*PP_W-1:0]     sq_full;
  logic [DATA_WIDTH-1:0] sq;
  logic [DATA_WIDTH-1:0] sum_nxt;

  // diff^2 mod 2^64 = lo*lo + (lo*hi << 33)
  assign diff_ext = (2*PP_W)'(diff_q);
  assign lo       = diff_ext[PP_W-1:0];
  assign hi       = diff_ext[2*PP_W-1:PP_W];
  assign p0_d     = {{PP_W{1'b0}}, lo} * {{PP_W{1'b0}}, lo};
  assign p1_d     = lo * hi;
  assign sq_full  = p0_q + {p1_q[PP_W-2:0], {(PP_W+1){1'b0}}};
  assign sq       = DATA_WIDTH'(sq_full);
  assign sum_nxt  = sum_q + sq;

  always_comb begin
    sum_d = sum_q;
    if (s2_vld_q) begin
      sum_d = s2_last_q ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_vld_q    <= 1'b0;
      s2_last_q   <= 1'b0;
      step_vld_q  <= 1'b0;
      step_last_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      s1_vld_q    <= start_i;
      s1_last_q   <= last_i;
      s2_vld_q    <= s1_vld_q;
      s2_last_q   <= s1_last_q;
      step_vld_q  <= s2_vld_q;
      step_last_q <= s2_last_q;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      diff_q <= DATA_WIDTH'(coordinate_i) - DATA_WIDTH'(mask_i);
    end
    if (s1_vld_q) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
    if (s2_vld_q && s2_last_q) begin
      pdist_q <= sum_nxt;
    end
  end

  assign step_vld_o   = step_vld_q;
  assign step_last_o  = step_last_q;
  assign point_dist_o = pdist_q;

endmodule

`default_nettype wire

// ===== sv/dtsd_cell.sv =====
// one list slot: holds a distance and id and acts on the token passing through
// depends on dtsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtsd_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  clear_i,
  input  wire logic [DATA_WIDTH-1:0] ceil_i,
  input  wire dtsd_pkg::tok_t        tok_i,
  input  wire logic [DATA_WIDTH-1:0] dist_i,
  input  wire logic [DATA_WIDTH-1:0] id_i,
  output dtsd_pkg::tok_t             tok_o,
  output logic [DATA_WIDTH-1:0]      dist_o,
  output logic [DATA_WIDTH-1:0]      id_o
);
  import dtsd_pkg::*;

  localparam bit                IdxInRange = (IDX < (1 << SLOT_W));
  localparam logic [SLOT_W-1:0] IdxCode    = SLOT_W'(IDX);

  logic [DATA_WIDTH-1:0] dist_q, dist_d;
  logic [DATA_WIDTH-1:0] id_q, id_d;
  tok_t                  tok_q, tok_d;
  logic [DATA_WIDTH-1:0] cdist_q, cdist_d;
  logic [DATA_WIDTH-1:0] cid_q, cid_d;
  logic                  slot_hit;

  assign slot_hit = IdxInRange && (tok_i.slot == IdxCode);

  always_comb begin
    dist_d  = dist_q;
    id_d    = id_q;
    tok_d   = tok_i;
    cdist_d = dist_i;
    cid_d   = id_i;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_DUP: begin
          tok_d.dup = tok_i.dup | (id_q == id_i);
        end
        OP_INS: begin
          // held entry stays ahead on equal distance
          if (dist_q > dist_i) begin
            dist_d  = dist_i;
            id_d    = id_i;
            cdist_d = dist_q;
            cid_d   = id_q;
          end
        end
        OP_RD: begin
          if (slot_hit) begin
            cdist_d = dist_q;
            cid_d   = id_q;
          end
        end
        default: begin
          tok_d.vld = 1'b0;
        end
      endcase
    end
    if (clear_i) begin
      dist_d = ceil_i;
      id_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= DATA_WIDTH'(CEIL_RESET);
      id_q   <= '0;
      tok_q  <= '0;
    end else begin
      dist_q <= dist_d;
      id_q   <= id_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cdist_q <= cdist_d;
    cid_q   <= cid_d;
  end

  assign tok_o  = tok_q;
  assign dist_o = cdist_q;
  assign id_o   = cid_q;

endmodule

`default_nettype wire

// ===== sv/dedup_topk_squared_distance_core.sv =====
// top level of the deduplicating top-k squared distance core
// depends on dtsd_pkg, dtsd_in_if, dtsd_out_if, dtsd_sqacc and dtsd_cell
//
//   channel   direction  kind                 moves
//   req_i     in         valid/ready          coordinate, read-out or clear transaction
//   rsp_o     out        valid/ready          one masked slot per read-out
//   cfg_*     in         write enable + data  distance_ceiling
//
// a coordinate that is not the last of its point holds off the next one until
//   it has passed the three squarer stages
// a last coordinate then sends one token through the cell chain for the
//   duplicate check, then a second one for the insertion
// a read-out walks the chain once, then waits for a free output register;
//   a clear sets every slot to the distance ceiling with id 0
// reset puts every slot at 0xFFFFFFFF with id 0, no clearing pass
// a stalled result sits in the output register; the next transaction is
//   still accepted and a later read-out waits only at the hand-over
`timescale 1ns / 1ps
`default_nettype none

module dedup_topk_squared_distance_core #(
  parameter int unsigned TOP_K      = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dtsd_pkg::FIELD_W-1:0] cfg_wdata_i,
  dtsd_in_if.sink                           req_i,
  dtsd_out_if.source                        rsp_o
);
  import dtsd_pkg::*;

  // distance ceiling register
  logic [FIELD_W-1:0]    ceil_q;
  logic [DATA_WIDTH-1:0] ceil_dw;

  // control
  state_e                state_q, state_d;
  logic                  req_acc;
  logic                  acc_start;
  logic                  clear;

  // accumulator results
  logic                  step_vld, step_last;
  logic [DATA_WIDTH-1:0] point_dist;

  // cell chain, one token at a time
  tok_t                  chain_tok  [TOP_K+1];
  logic [DATA_WIDTH-1:0] chain_dist [TOP_K+1];
  logic [DATA_WIDTH-1:0] chain_id   [TOP_K+1];
  tok_t                  launch_tok;
  logic [DATA_WIDTH-1:0] launch_dist, launch_id;
  tok_t                  exit_tok;

  // point and read-out payload
  logic [DATA_WIDTH-1:0] pid_q;
  logic [FIELD_W-1:0]    rnd_id_q, rnd_dist_q;
  logic [DATA_WIDTH-1:0] res_dist_q, res_id_q;
  logic [SLOT_W-1:0]     res_slot_q;

  // output register
  logic                  rsp_vld_q, rsp_vld_d;
  logic                  load_out;
  logic [FIELD_W-1:0]    rsp_dist_q, rsp_id_q;
  logic [SLOT_W-1:0]     rsp_slot_q;

  assign ceil_dw   = DATA_WIDTH'(ceil_q);
  assign req_acc   = req_i.valid && req_i.ready;
  assign exit_tok  = chain_tok[TOP_K];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= CEIL_RESET;
    end else if (cfg_we_i) begin
      ceil_q <= cfg_wdata_i;
    end
  end

  dtsd_sqacc #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sqacc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (acc_start),
    .coordinate_i (req_i.coordinate),
    .mask_i       (req_i.mask),
    .last_i       (req_i.last_dim),
    .step_vld_o   (step_vld),
    .step_last_o  (step_last),
    .point_dist_o (point_dist)
  );

  assign chain_tok[0]  = launch_tok;
  assign chain_dist[0] = launch_dist;
  assign chain_id[0]   = launch_id;

  for (genvar g = 0; g < TOP_K; g++) begin : g_cell
    dtsd_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .ceil_i  (ceil_dw),
      .tok_i   (chain_tok[g]),
      .dist_i  (chain_dist[g]),
      .id_i    (chain_id[g]),
      .tok_o   (chain_tok[g+1]),
      .dist_o  (chain_dist[g+1]),
      .id_o    (chain_id[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: starts the squarer, launches tokens, clears the slots, hands results over
  always_comb begin
    state_d     = state_q;
    req_i.ready = (state_q == ST_IDLE);
    acc_start   = 1'b0;
    clear       = 1'b0;
    load_out    = 1'b0;
    launch_tok  = '0;
    launch_dist = ceil_dw;
    launch_id   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (mode_e'(req_i.mode))
            MODE_COORD: begin
              acc_start = 1'b1;
              state_d   = ST_SQ;
            end
            MODE_READ: begin
              // an out-of-range slot leaves the empty-slot values in place
              launch_tok.vld  = 1'b1;
              launch_tok.op   = OP_RD;
              launch_tok.slot = req_i.slot;
              state_d         = ST_RD;
            end
            MODE_CLEAR: begin
              clear = 1'b1;
            end
            MODE_NONE: begin
            end
          endcase
        end
      end
      ST_SQ: begin
        if (step_vld) begin
          if (step_last) begin
            launch_tok.vld = 1'b1;
            launch_tok.op  = OP_DUP;
            launch_id      = pid_q;
            state_d        = ST_DUP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DUP: begin
        if (exit_tok.vld) begin
          launch_tok.vld = 1'b1;
          launch_tok.op  = OP_INS;
          launch_dist    = exit_tok.dup ? ceil_dw - DATA_WIDTH'(1) : point_dist;
          launch_id      = exit_tok.dup ? '0 : pid_q;
          state_d        = ST_INS;
        end
      end
      ST_INS: begin
        if (exit_tok.vld) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        if (exit_tok.vld) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      pid_q      <= DATA_WIDTH'(req_i.label) - DATA_WIDTH'(req_i.mask);
      rnd_id_q   <= req_i.rand_id;
      rnd_dist_q <= req_i.rand_dist;
    end
    if (state_q == ST_RD && exit_tok.vld) begin
      res_dist_q <= chain_dist[TOP_K];
      res_id_q   <= chain_id[TOP_K];
      res_slot_q <= exit_tok.slot;
    end
    if (load_out) begin
      rsp_dist_q <= FIELD_W'(res_dist_q - DATA_WIDTH'(rnd_dist_q));
      rsp_id_q   <= FIELD_W'(res_id_q ^ DATA_WIDTH'(rnd_id_q));
      rsp_slot_q <= res_slot_q;
    end
  end

  assign rsp_vld_d = load_out | (rsp_vld_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= rsp_vld_d;
    end
  end

  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.masked_distance = rsp_dist_q;
  assign rsp_o.masked_id       = rsp_id_q;
  assign rsp_o.slot_echo       = rsp_slot_q;

  // a token only leaves the chain while the sequencer waits for it
  a_exit_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_tok.vld |-> (state_q == ST_DUP || state_q == ST_INS || state_q == ST_RD))
    else $error("token left the cell chain unexpectedly");

  // squarer results arrive only while a coordinate is in flight
  a_step_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_vld |-> state_q == ST_SQ)
    else $error("squarer step outside coordinate processing");

  // an accepted coordinate engages the squarer
  a_coord_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.mode == MODE_COORD) |=> state_q == ST_SQ)
    else $error("coordinate transaction did not start the squarer");

  // a new result only appears after a read-out hand-over
  a_rsp_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vld_q) |-> $past(state_q == ST_PUSH))
    else $error("result raised without a read-out");

endmodule

`default_nettype wire
